// ----- hdl/hsd_pkg.sv -----
// hsd_pkg: shared types, constants and the data position table
// for the hamming secded decoder; no dependencies
`default_nettype none

package hsd_pkg;

  localparam int LEN_W              = 7;
  localparam int MSG_W              = 57;
  localparam int SYN_W              = 7;
  localparam int R_W                = 3;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 7;
  localparam int DEFAULT_MAX_LENGTH = 64;
  localparam int CODEWORD_W         = 64;
  localparam int MIN_LENGTH         = 3;
  localparam int RESET_CODE_LENGTH  = 7;
  localparam int QUEUE_DEPTH        = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_LENGTH   = 1'b0,
    CFG_EXTENDED_MODE = 1'b1
  } cfg_reg_t;

  // decode status codes
  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_DOUBLE    = 2'd2,
    ST_MULTI     = 2'd3
  } status_t;

  // per-word control handed from the front to the back
  typedef struct packed {
    logic [LEN_W-1:0] idx;   // index syndrome
    logic             par;   // overall parity of the masked word
    logic [LEN_W-1:0] n;     // clamped length
    logic [LEN_W-1:0] nn;    // length of the index part
    logic [R_W-1:0]   r;     // index syndrome width
    logic             ext;   // extended mode
  } hsd_ctrl_t;

  // one-based position of message bit j: the j-th non-power-of-two from 3 up
  function automatic logic [LEN_W-1:0] data_pos(input int j);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 3; p < CODEWORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == j) begin
          pos = p;
        end
        cnt = cnt + 1;
      end
    end
    return LEN_W'(pos);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hsd_front.sv -----
// hsd_front: configuration registers, input word capture, length masking
// and syndrome / parity xor trees; uses hsd_pkg
`default_nettype none

module hsd_front import hsd_pkg::*; #(
  parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CODEWORD_W-1:0] codeword,
  output logic                       push,
  input  wire logic                  q_full,
  output hsd_ctrl_t                  front_ctrl,
  output logic [MAX_LENGTH-1:0]      front_word
);

  logic [LEN_W-1:0]      code_length;
  logic                  extended_mode;
  logic                  front_valid;
  logic                  front_valid_next;
  logic                  accept;
  logic [LEN_W-1:0]      n_eff;
  logic [LEN_W-1:0]      nn_eff;
  logic [R_W-1:0]        r_eff;
  logic [MAX_LENGTH-1:0] word_m;
  logic [LEN_W-1:0]      idx_c;
  logic                  par_c;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length   <= LEN_W'(RESET_CODE_LENGTH);
      extended_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CODE_LENGTH:   code_length   <= cfg_data[LEN_W-1:0];
        CFG_EXTENDED_MODE: extended_mode <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // clamp length, index part length and syndrome width
  always_comb begin
    if (code_length < LEN_W'(MIN_LENGTH)) begin
      n_eff = LEN_W'(MIN_LENGTH);
    end else if (code_length > LEN_W'(MAX_LENGTH)) begin
      n_eff = LEN_W'(MAX_LENGTH);
    end else begin
      n_eff = code_length;
    end
    nn_eff = extended_mode ? n_eff - LEN_W'(1) : n_eff;
    r_eff = R_W'(2);
    for (int k = 2; k < 7; k++) begin
      if ({1'b0, nn_eff} >= (8'd1 << k)) begin
        r_eff = R_W'(k + 1);
      end
    end
  end

  // mask past length, then xor trees for index syndrome and parity
  always_comb begin
    idx_c = '0;
    for (int i = 0; i < MAX_LENGTH; i++) begin
      word_m[i] = codeword[i] & (LEN_W'(i + 1) <= n_eff);
      if (word_m[i] && (LEN_W'(i + 1) <= nn_eff)) begin
        idx_c = idx_c ^ LEN_W'(i + 1);
      end
    end
    par_c = ^word_m;
  end

  // stage handshake
  assign in_stall = front_valid & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = front_valid & ~q_full;
  assign front_valid_next = accept | (front_valid & q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      front_word     <= word_m;
      front_ctrl.idx <= idx_c;
      front_ctrl.par <= par_c;
      front_ctrl.n   <= n_eff;
      front_ctrl.nn  <= nn_eff;
      front_ctrl.r   <= r_eff;
      front_ctrl.ext <= extended_mode;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hsd_queue.sv -----
// hsd_queue: short fifo between the front and the back
// generic width; depth from hsd_pkg
`default_nettype none

module hsd_queue import hsd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hsd_back.sv -----
// hsd_back: error classification, bit correction, data extraction
// and the output register; uses hsd_pkg
`default_nettype none

module hsd_back import hsd_pkg::*; #(
  parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire hsd_ctrl_t             q_ctrl,
  input  wire logic [MAX_LENGTH-1:0] q_word,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [MSG_W-1:0]           message,
  output logic [SYN_W-1:0]           syndrome,
  output logic [1:0]                 status,
  output logic [LEN_W-1:0]           error_position
);

  localparam int POS_W = $clog2(CODEWORD_W);

  logic                  take;
  status_t               st_c;
  logic [LEN_W-1:0]      epos_c;
  logic [SYN_W-1:0]      synd_c;
  logic [MAX_LENGTH-1:0] corr;
  logic [CODEWORD_W-1:0] corr_w;
  logic [MSG_W-1:0]      msg_c;

  // classify
  always_comb begin
    st_c   = ST_CLEAN;
    epos_c = '0;
    if (q_ctrl.ext) begin
      synd_c = q_ctrl.idx | (SYN_W'(q_ctrl.par) << q_ctrl.r);
      if (q_ctrl.par) begin
        if (q_ctrl.idx > q_ctrl.nn) begin
          st_c = ST_MULTI;
        end else begin
          epos_c = (q_ctrl.idx != '0) ? q_ctrl.idx : q_ctrl.n;
          st_c   = ST_CORRECTED;
        end
      end else if (q_ctrl.idx != '0) begin
        st_c = ST_DOUBLE;
      end
    end else begin
      synd_c = q_ctrl.idx;
      if (q_ctrl.idx != '0) begin
        if (q_ctrl.idx > q_ctrl.n) begin
          st_c = ST_DOUBLE;
        end else begin
          epos_c = q_ctrl.idx;
          st_c   = ST_CORRECTED;
        end
      end
    end
  end

  // flip the bad bit and gather the data positions
  always_comb begin
    for (int i = 0; i < MAX_LENGTH; i++) begin
      corr[i] = q_word[i] ^ (epos_c == LEN_W'(i + 1));
    end
    corr_w = CODEWORD_W'(corr);
    for (int j = 0; j < MSG_W; j++) begin
      msg_c[j] = corr_w[POS_W'(data_pos(j) - LEN_W'(1))] & (data_pos(j) <= q_ctrl.nn)
                 & ((st_c == ST_CLEAN) || (st_c == ST_CORRECTED));
    end
  end

  // output register
  assign take = q_valid & (~out_valid | ~out_stall);
  assign pop  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      message        <= msg_c;
      syndrome       <= synd_c;
      status         <= st_c;
      error_position <= epos_c;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hamming_secded_decoder.sv -----
// hamming_secded_decoder: top level, front stage, queue and back stage
// depends on hsd_pkg, hsd_front, hsd_queue, hsd_back
//
//   channel   direction   handshake             payload
//   cfg       in          cfg_valid/cfg_ready   cfg_index, cfg_data
//   in        in          in_valid/in_stall     codeword
//   out       out         out_valid/out_stall   message, syndrome, status,
//                                               error_position
//
// one word per cycle sustained while out is not stalled; a taken word passes
// through the front register, then the queue, then the output register,
// which raises out_valid
// rst is synchronous and clears all valid flags and the configuration
// the two-entry queue lets the front keep taking words while out is stalled
`default_nettype none

module hamming_secded_decoder import hsd_pkg::*; #(
  parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CODEWORD_W-1:0] codeword,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [MSG_W-1:0]           message,
  output logic [SYN_W-1:0]           syndrome,
  output logic [1:0]                 status,
  output logic [LEN_W-1:0]           error_position
);

  localparam int Q_W = MAX_LENGTH + $bits(hsd_ctrl_t);

  logic                  push;
  logic                  q_full;
  logic                  pop;
  logic                  q_valid;
  hsd_ctrl_t             front_ctrl;
  logic [MAX_LENGTH-1:0] front_word;
  logic [Q_W-1:0]        q_rdata;
  hsd_ctrl_t             q_ctrl;
  logic [MAX_LENGTH-1:0] q_word;

  // front: config, capture, syndrome
  hsd_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .codeword  (codeword),
    .push      (push),
    .q_full    (q_full),
    .front_ctrl(front_ctrl),
    .front_word(front_word)
  );

  // queue between front and back
  hsd_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  ({front_ctrl, front_word}),
    .full   (q_full),
    .pop    (pop),
    .q_valid(q_valid),
    .rdata  (q_rdata)
  );

  assign q_ctrl = q_rdata[Q_W-1:MAX_LENGTH];
  assign q_word = q_rdata[MAX_LENGTH-1:0];

  // back: correct, extract, output register
  hsd_back #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ctrl        (q_ctrl),
    .q_word        (q_word),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .message       (message),
    .syndrome      (syndrome),
    .status        (status),
    .error_position(error_position)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking testbench for hamming_secded_decoder, with a clocked driver and monitor
// and a decode predictor and scoreboard; depends on hsd_pkg and hamming_secded_decoder
`timescale 1ns / 100ps

module tb;
  import hsd_pkg::*;

  localparam int NUM_PHASES    = 14;
  localparam int RANDOM_WORDS  = 90;
  localparam int HOLD_PHASE    = 4;
  localparam int QUIET_PHASE   = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_LEN       = DEFAULT_MAX_LENGTH;

  // one decoded result
  typedef struct packed {
    logic [MSG_W-1:0] message;
    logic [SYN_W-1:0] syndrome;
    status_t          status;
    logic [LEN_W-1:0] error_position;
  } decode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CODEWORD_W-1:0] codeword = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MSG_W-1:0]      message;
  logic [SYN_W-1:0]      syndrome;
  logic [1:0]            status;
  logic [LEN_W-1:0]      error_position;

  // shadow of the configuration registers
  logic [LEN_W-1:0] len_reg = LEN_W'(RESET_CODE_LENGTH);
  logic             ext_reg = 1'b0;

  logic [CODEWORD_W-1:0] pending_words[$];
  decode_t               expected_decodes[$];

  int  mismatch_cnt = 0;
  int  taken_cnt = 0;
  int  phase_no = 0;
  int  phase_base = 0;
  int  tx_idle_pct = 30;
  int  rx_idle_pct = 30;
  int  tx_gap = 0;
  int  rx_stall_left = 0;
  logic out_hold = 1'b0;

  int cfg_len_tbl [NUM_PHASES] = '{7, 12, 12, 64, 64, 3, 3, 0, 127, 65, 16, 8, -1, -1};
  int cfg_ext_tbl [NUM_PHASES] = '{0, 0, 1, 0, 1, 0, 1, 1, 0, 1, 0, 1, -1, -1};

  hamming_secded_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .codeword       (codeword),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .message        (message),
    .syndrome       (syndrome),
    .status         (status),
    .error_position (error_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // saturate the length register into the legal range
  function automatic int clamp_len(input logic [LEN_W-1:0] len_val);
    int n;
    n = len_val;
    if (n < MIN_LENGTH) n = MIN_LENGTH;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  // expected decode of one word under the given configuration
  function automatic decode_t predict_decode(input logic [CODEWORD_W-1:0] cw,
                                             input logic [LEN_W-1:0] len_val,
                                             input logic ext_mode);
    decode_t               res;
    logic [CODEWORD_W-1:0] w;
    int                    n, nn, r, idx, par, epos, i, j;
    status_t               st;
    n = clamp_len(len_val);
    nn = ext_mode ? n - 1 : n;
    w = cw & ((64'd1 << n) - 64'd1);
    r = 2;
    while (r < 7 && (1 << r) <= nn) r++;
    idx = 0;
    par = 0;
    epos = 0;
    st = ST_CLEAN;
    for (i = 1; i <= n; i++) begin
      if (w[i-1]) begin
        par ^= 1;
        if (i <= nn) idx ^= i;
      end
    end
    if (ext_mode) begin
      res.syndrome = SYN_W'(idx | (par << r));
      if (par != 0) begin
        if (idx > nn) begin
          st = ST_MULTI;
        end else begin
          epos = (idx != 0) ? idx : n;
          st = ST_CORRECTED;
        end
      end else if (idx != 0) begin
        st = ST_DOUBLE;
      end
    end else begin
      res.syndrome = SYN_W'(idx);
      if (idx != 0) begin
        if (idx > n) begin
          st = ST_DOUBLE;
        end else begin
          epos = idx;
          st = ST_CORRECTED;
        end
      end
    end
    if (epos != 0) w[epos-1] = ~w[epos-1];
    // gather data bits from the non-power-of-two positions
    res.message = '0;
    if (st == ST_CLEAN || st == ST_CORRECTED) begin
      j = 0;
      for (i = 3; i <= nn; i++) begin
        if ((i & (i - 1)) != 0) begin
          if (j < MSG_W) res.message[j] = w[i-1];
          j++;
        end
      end
    end
    res.status = st;
    res.error_position = LEN_W'(epos);
    return res;
  endfunction

  // valid codeword for the current configuration from random content
  function automatic logic [CODEWORD_W-1:0] encode_word(input logic [CODEWORD_W-1:0] raw);
    logic [CODEWORD_W-1:0] w;
    int                    n, nn, idx, par, i;
    n = clamp_len(len_reg);
    nn = ext_reg ? n - 1 : n;
    w = raw & ((64'd1 << n) - 64'd1);
    for (i = 1; i <= n; i++) begin
      if ((i & (i - 1)) == 0 && i <= nn) w[i-1] = 1'b0;
    end
    if (ext_reg) w[n-1] = 1'b0;
    idx = 0;
    for (i = 1; i <= nn; i++) begin
      if (w[i-1]) idx ^= i;
    end
    for (i = 0; i < 7; i++) begin
      if (idx[i]) w[(1 << i) - 1] = 1'b1;
    end
    if (ext_reg) begin
      par = 0;
      for (i = 1; i <= n; i++) par ^= w[i-1];
      w[n-1] = par[0];
    end
    return w;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %0h want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CODE_LENGTH) len_reg = data;
    else ext_reg = data[0];
  endtask

  // valid codeword with the given positions flipped
  task automatic add_coded(input logic [CODEWORD_W-1:0] flip_mask);
    pending_words.push_back(encode_word({$urandom, $urandom}) ^ flip_mask);
  endtask

  // mostly codewords with zero to three errors, the rest raw noise
  task automatic add_random_word();
    logic [CODEWORD_W-1:0] w, fm, low_mask;
    int                    n, k, p, roll;
    n = clamp_len(len_reg);
    low_mask = (64'd1 << n) - 64'd1;
    if ($urandom_range(99) < 25) begin
      w = {$urandom, $urandom};
    end else begin
      roll = $urandom_range(99);
      k = (roll < 25) ? 0 : (roll < 65) ? 1 : (roll < 85) ? 2 : 3;
      fm = '0;
      while (k > 0) begin
        p = $urandom_range(n, 1);
        if (!fm[p-1]) begin
          fm[p-1] = 1'b1;
          k--;
        end
      end
      w = encode_word({$urandom, $urandom}) ^ fm;
      // junk above the length is ignored
      if ($urandom_range(9) < 3) w = w ^ ({$urandom, $urandom} & ~low_mask);
    end
    pending_words.push_back(w);
  endtask

  // driver: offers pending words, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_decodes.push_back(predict_decode(codeword, len_reg, ext_reg));
        taken_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          codeword <= pending_words.pop_front();
          in_valid <= 1'b1;
          tx_gap <= ($urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result, drives random stall
  always @(posedge clk) begin
    decode_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch("result with no word pending", 64'(syndrome), 64'd0);
        end else begin
          want = expected_decodes.pop_front();
          if (message !== want.message)
            report_mismatch("message", 64'(message), 64'(want.message));
          if (syndrome !== want.syndrome)
            report_mismatch("syndrome", 64'(syndrome), 64'(want.syndrome));
          if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
          if (error_position !== want.error_position)
            report_mismatch("error_position", 64'(error_position),
                            64'(want.error_position));
        end
      end
      if (out_hold) begin
        out_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        out_stall <= 1'b1;
        rx_stall_left <= rx_stall_left - 1;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        rx_stall_left <= pick_gap() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the decoder backs up and stalls its input
  initial begin
    while (phase_no != HOLD_PHASE || taken_cnt - phase_base < 20) @(negedge clk);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    out_hold = 1'b0;
  end

  // phases: configure while idle, queue words, drain
  initial begin
    int len_val;
    int ext_val;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      if (ph != 0) begin
        len_val = (cfg_len_tbl[ph] < 0) ? $urandom_range(127) : cfg_len_tbl[ph];
        ext_val = (cfg_ext_tbl[ph] < 0) ? $urandom_range(1) : cfg_ext_tbl[ph];
        write_reg(CFG_CODE_LENGTH, CFG_DATA_W'(len_val));
        write_reg(CFG_EXTENDED_MODE, {6'($urandom_range(63)), ext_val[0]});
      end
      @(negedge clk);
      phase_base = taken_cnt;
      phase_no = ph;
      tx_idle_pct = (ph == QUIET_PHASE) ? 0 : 30;
      rx_idle_pct = (ph == QUIET_PHASE) ? 0 : 30;
      // directed words for this setting
      case (ph)
        0: begin
          pending_words.push_back('0);
          pending_words.push_back('1);
          pending_words.push_back(64'hFFFF_FFFF_FFFF_FF80);
          add_coded(64'h4);
          add_coded(64'h3);
        end
        1: begin
          add_coded('0);
          // syndrome points past a shortened length
          add_coded(64'h801);
          add_coded(64'h800);
        end
        2: begin
          // only the parity bit flipped
          add_coded(64'h800);
          // triple error pointing past the index part
          add_coded(64'h89);
          add_coded(64'h12);
          add_coded(64'h40);
          pending_words.push_back('1);
          pending_words.push_back('0);
        end
        3: begin
          pending_words.push_back('1);
          add_coded(64'h8000_0000_0000_0000);
          add_coded(64'h1);
        end
        4: begin
          add_coded(64'h8000_0000_0000_0000);
          pending_words.push_back('1);
        end
        default: ;
      endcase
      repeat (RANDOM_WORDS) add_random_word();
      while (pending_words.size() != 0 || in_valid || expected_decodes.size() != 0)
        @(negedge clk);
    end
    repeat (10) @(posedge clk);
    if (expected_decodes.size() != 0)
      report_mismatch("results never arrived", 64'(expected_decodes.size()), 64'd0);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
